>>> rtl/core/tts_pkg.sv
// Shared types and constants for the tone timer setting block.
`default_nettype none
package tts_pkg;

  localparam int FREQ_W = 18;
  localparam int CLK_W = 28;
  localparam int NUM_W = CLK_W + 4;
  localparam int DEN_W = FREQ_W + 5;
  localparam int REM_W = DEN_W + 1;
  localparam int PSC_W = 5;
  localparam int STEPS_PER_STAGE = 4;
  localparam int DIV_STAGES = NUM_W / STEPS_PER_STAGE;
  localparam int PERIOD_BITS_DEF = 16;
  localparam int ADDR_W = 2;
  localparam int DATA_W = 32;

  localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(72000000);
  localparam logic [ADDR_W-1:0] ADDR_CLOCK_HZ = '0;

  // band limits in Q14.4: 100, 200, 400, 700, 1300 Hz
  localparam logic [FREQ_W-1:0] BAND_100 = FREQ_W'(1600);
  localparam logic [FREQ_W-1:0] BAND_200 = FREQ_W'(3200);
  localparam logic [FREQ_W-1:0] BAND_400 = FREQ_W'(6400);
  localparam logic [FREQ_W-1:0] BAND_700 = FREQ_W'(11200);
  localparam logic [FREQ_W-1:0] BAND_1300 = FREQ_W'(20800);

  localparam logic [PSC_W-1:0] PSC_32 = PSC_W'(31);
  localparam logic [PSC_W-1:0] PSC_16 = PSC_W'(15);
  localparam logic [PSC_W-1:0] PSC_8 = PSC_W'(7);
  localparam logic [PSC_W-1:0] PSC_4 = PSC_W'(3);
  localparam logic [PSC_W-1:0] PSC_2 = PSC_W'(1);
  localparam logic [PSC_W-1:0] PSC_1 = PSC_W'(0);

  // numq: numerator bits leave at the top, quotient bits enter at the bottom
  typedef struct packed {
    logic             silent;
    logic [PSC_W-1:0] psc;
    logic [NUM_W-1:0] numq;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
  } tts_work_t;

endpackage
`default_nettype wire

>>> rtl/core/tts_cfg.sv
// Configuration register file: clock frequency register on an APB-style port.
`default_nettype none
module tts_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tts_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tts_pkg::DATA_W-1:0]  pwdata,
  output logic      [tts_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic      [tts_pkg::CLK_W-1:0]   clock_hz
);
  import tts_pkg::*;

  logic [CLK_W-1:0] clock_hz_r;
  logic [CLK_W-1:0] clock_hz_nxt;

  always_comb begin
    clock_hz_nxt = clock_hz_r;
    if (psel && penable && pwrite && paddr == ADDR_CLOCK_HZ) begin
      clock_hz_nxt = pwdata[CLK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLOCK_RESET;
    end else begin
      clock_hz_r <= clock_hz_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CLOCK_HZ) ? DATA_W'(clock_hz_r) : '0;
  assign clock_hz = clock_hz_r;

endmodule
`default_nettype wire

>>> rtl/core/tts_front.sv
// Front stage: band decode, prescaler pick and divider operand set-up.
`default_nettype none
module tts_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        up_valid,
  input  wire logic [tts_pkg::FREQ_W-1:0]  freq_q4,
  input  wire logic [tts_pkg::CLK_W-1:0]   clock_hz,
  output logic                             up_ready,
  input  wire logic                        dn_ready,
  output logic                             valid,
  output tts_pkg::tts_work_t               data
);
  import tts_pkg::*;

  logic      valid_r;
  tts_work_t data_r;
  tts_work_t data_nxt;
  logic [2:0] shift;

  always_comb begin
    if (freq_q4 < BAND_100) begin
      data_nxt.psc = PSC_32;
      shift = 3'd5;
    end else if (freq_q4 < BAND_200) begin
      data_nxt.psc = PSC_16;
      shift = 3'd4;
    end else if (freq_q4 < BAND_400) begin
      data_nxt.psc = PSC_8;
      shift = 3'd3;
    end else if (freq_q4 < BAND_700) begin
      data_nxt.psc = PSC_4;
      shift = 3'd2;
    end else if (freq_q4 < BAND_1300) begin
      data_nxt.psc = PSC_2;
      shift = 3'd1;
    end else begin
      data_nxt.psc = PSC_1;
      shift = 3'd0;
    end
    data_nxt.silent = (freq_q4 == '0);
    data_nxt.den = DEN_W'(freq_q4) << shift;
    data_nxt.numq = {clock_hz, 4'b0000};
    data_nxt.rem = '0;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign valid = valid_r;
  assign data = data_r;

endmodule
`default_nettype wire

>>> rtl/core/tts_div_stage.sv
// Divider stage: STEPS_PER_STAGE restoring long-division steps and a pipeline register.
`default_nettype none
module tts_div_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               up_valid,
  input  wire tts_pkg::tts_work_t up_data,
  output logic                    up_ready,
  input  wire logic               dn_ready,
  output logic                    valid,
  output tts_pkg::tts_work_t      data
);
  import tts_pkg::*;

  logic      valid_r;
  tts_work_t data_r;
  tts_work_t data_nxt;

  always_comb begin
    logic [REM_W-1:0] trial;
    logic             qbit;
    data_nxt = up_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      trial = {data_nxt.rem[REM_W-2:0], data_nxt.numq[NUM_W-1]};
      qbit = (trial >= {1'b0, data_nxt.den});
      data_nxt.rem = qbit ? (trial - {1'b0, data_nxt.den}) : trial;
      data_nxt.numq = {data_nxt.numq[NUM_W-2:0], qbit};
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign valid = valid_r;
  assign data = data_r;

endmodule
`default_nettype wire

>>> rtl/core/tts_out.sv
// Output stage: saturation, half-period compare value and result register.
`default_nettype none
module tts_out #(
  parameter int PERIOD_BITS = tts_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       up_valid,
  input  wire tts_pkg::tts_work_t         up_data,
  output logic                            up_ready,
  input  wire logic                       out_stall,
  output logic                            out_valid,
  output logic [tts_pkg::PSC_W-1:0]       out_prescale_sel,
  output logic [PERIOD_BITS-1:0]          out_period_count,
  output logic [PERIOD_BITS-2:0]          out_compare_count,
  output logic                            out_timing_valid,
  output logic                            out_period_clamped
);
  import tts_pkg::*;

  localparam logic [NUM_W:0] PMAX = (NUM_W+1)'((64'd1 << PERIOD_BITS) - 64'd1);

  logic                   valid_r;
  logic [PSC_W-1:0]       psc_r, psc_nxt;
  logic [PERIOD_BITS-1:0] period_r, period_nxt;
  logic                   timing_r, timing_nxt;
  logic                   clamped_r, clamped_nxt;
  logic                   over;

  always_comb begin
    over = ({1'b0, up_data.numq} > PMAX);
    if (up_data.silent) begin
      psc_nxt = '0;
      period_nxt = '0;
      timing_nxt = 1'b0;
      clamped_nxt = 1'b0;
    end else begin
      psc_nxt = up_data.psc;
      period_nxt = over ? '1 : up_data.numq[PERIOD_BITS-1:0];
      timing_nxt = 1'b1;
      clamped_nxt = over;
    end
  end

  assign up_ready = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      psc_r <= psc_nxt;
      period_r <= period_nxt;
      timing_r <= timing_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_prescale_sel = psc_r;
  assign out_period_count = period_r;
  assign out_compare_count = period_r[PERIOD_BITS-1:1];
  assign out_timing_valid = timing_r;
  assign out_period_clamped = clamped_r;

endmodule
`default_nettype wire

>>> rtl/core/tone_timer_setting.sv
// Top level of the tone timer setting block.
// Takes one request per cycle while the output is not stalled and gives one
// result per request: one front stage picks the prescaler and sets up the
// divider, eight divider stages each resolve four quotient bits of clock_hz*16 /
// (freq_q4*(prescaler+1)), and one output stage saturates the period and
// registers the result. Every stage holds its request under stall, so
// throughput stays at one per cycle while the result side keeps taking.
// clock_hz is written through the APB-style port at byte address 0 (reset
// 72 MHz) and should only change while no request is in flight.
`default_nettype none
module tone_timer_setting #(
  parameter int PERIOD_BITS = tts_pkg::PERIOD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [tts_pkg::FREQ_W-1:0]  in_freq_q4,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [tts_pkg::PSC_W-1:0]   out_prescale_sel,
  output logic      [PERIOD_BITS-1:0]      out_period_count,
  output logic      [PERIOD_BITS-2:0]      out_compare_count,
  output logic                             out_timing_valid,
  output logic                             out_period_clamped,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tts_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [tts_pkg::DATA_W-1:0]  pwdata,
  output logic      [tts_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import tts_pkg::*;

  logic [CLK_W-1:0] clock_hz;
  logic             front_ready;
  logic             stg_valid [DIV_STAGES+1];
  tts_work_t        stg_data  [DIV_STAGES+1];
  logic             stg_ready [DIV_STAGES+1];

  tts_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .clock_hz (clock_hz)
  );

  tts_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .freq_q4  (in_freq_q4),
    .clock_hz (clock_hz),
    .up_ready (front_ready),
    .dn_ready (stg_ready[0]),
    .valid    (stg_valid[0]),
    .data     (stg_data[0])
  );

  assign in_stall = !front_ready;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    tts_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[i]),
      .up_data  (stg_data[i]),
      .up_ready (stg_ready[i]),
      .dn_ready (stg_ready[i+1]),
      .valid    (stg_valid[i+1]),
      .data     (stg_data[i+1])
    );
  end

  tts_out #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .up_valid           (stg_valid[DIV_STAGES]),
    .up_data            (stg_data[DIV_STAGES]),
    .up_ready           (stg_ready[DIV_STAGES]),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_prescale_sel   (out_prescale_sel),
    .out_period_count   (out_period_count),
    .out_compare_count  (out_compare_count),
    .out_timing_valid   (out_timing_valid),
    .out_period_clamped (out_period_clamped)
  );

  a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_timing_valid |->
      out_period_count == '0 && out_prescale_sel == '0 && !out_period_clamped)
    else $error("silent result carries timing fields");

  a_clamp_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period_clamped |-> &out_period_count && out_timing_valid)
    else $error("clamped period is not saturated");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stg_valid[0] && !stg_ready[0])
    else $error("input stalled while front stage can move");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg_valid[DIV_STAGES] && !stg_ready[DIV_STAGES] |=>
      stg_valid[DIV_STAGES] && $stable(stg_data[DIV_STAGES]))
    else $error("last divider stage lost a held request");

endmodule
`default_nettype wire
